// ===== design/kap_pkg.sv =====
// Shared types, constants and tables of the Kepler anomaly propagator.
package kap_pkg;

	localparam int ANGLE_BITS_DEF  = 32;
	localparam int NEWTON_ITER_DEF = 10;

	localparam int ECC_W = 16;
	localparam int SMA_W = 26;
	localparam int STP_W = 32;
	localparam int CFG_W = 32;
	localparam int IDX_W = 2;
	localparam int ANG_W = 32;
	localparam int RAD_W = 26;

	localparam logic [IDX_W-1:0] REG_ECC = 2'd0;
	localparam logic [IDX_W-1:0] REG_SMA = 2'd1;
	localparam logic [IDX_W-1:0] REG_STP = 2'd2;

	localparam int CORDIC_STEPS = 31;
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
	localparam logic signed [31:0] RAD_TO_ANGLE = 32'sd683565276;

	localparam int DIV_NUM_W  = 64;
	localparam int DIV_DEN_W  = 34;
	localparam int DIV_QLONG  = 33;
	localparam int DIV_QSHORT = 26;

	localparam logic [RAD_W-1:0] RADIUS_MAX = '1;

	// operation / controller state codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd0;
	localparam logic [OP_W-1:0] OP_NT_COR = 4'd1;
	localparam logic [OP_W-1:0] OP_NT_M1  = 4'd2;
	localparam logic [OP_W-1:0] OP_NT_M2  = 4'd3;
	localparam logic [OP_W-1:0] OP_NT_DIV = 4'd4;
	localparam logic [OP_W-1:0] OP_NT_UPD = 4'd5;
	localparam logic [OP_W-1:0] OP_P_COR  = 4'd6;
	localparam logic [OP_W-1:0] OP_P_SQP  = 4'd7;
	localparam logic [OP_W-1:0] OP_P_SQM  = 4'd8;
	localparam logic [OP_W-1:0] OP_P_MUL  = 4'd9;
	localparam logic [OP_W-1:0] OP_P_ATAN = 4'd10;
	localparam logic [OP_W-1:0] OP_P_COR2 = 4'd11;
	localparam logic [OP_W-1:0] OP_P_M1   = 4'd12;
	localparam logic [OP_W-1:0] OP_P_M2   = 4'd13;
	localparam logic [OP_W-1:0] OP_P_DIV  = 4'd14;
	localparam logic [OP_W-1:0] OP_OUT    = 4'd15;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            go;
	} kap_cmd_t;

	typedef struct packed {
		logic done;
		logic nt_last;
		logic out_busy;
	} kap_status_t;

	function automatic logic [29:0] arc_of(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0: a = 30'd536870912;
			5'd1: a = 30'd316933406;
			5'd2: a = 30'd167458907;
			5'd3: a = 30'd85004756;
			5'd4: a = 30'd42667331;
			5'd5: a = 30'd21354465;
			5'd6: a = 30'd10679838;
			5'd7: a = 30'd5340245;
			5'd8: a = 30'd2670163;
			5'd9: a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			5'd24: a = 30'd41;
			5'd25: a = 30'd20;
			5'd26: a = 30'd10;
			5'd27: a = 30'd5;
			5'd28: a = 30'd3;
			5'd29: a = 30'd1;
			5'd30: a = 30'd1;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/kepler_anomaly_propagator_top.sv =====
// Top level of the Kepler anomaly propagator.
//
// Input stream (s_*): one transaction per item. s_tuser is the mode (0 loads
// s_tdata as the new mean anomaly, 1 advances by the step increment); s_tdata
// is the mean anomaly to load.
// Output stream (m_*): one transaction per item with mean, eccentric and true
// anomaly (binary angles) and the radius in metres, saturated.
// Config port: cfg_we/cfg_index/cfg_data, write only, taken at any edge with
// cfg_we high; 0 eccentricity, 1 semi-major axis, 2 step increment.
// Per Newton iteration: a CORDIC rotation, the 33-step division and three
// further steps; then the half-angle rotation, two 31-step square roots,
// atan2, one more rotation and a 26-step division; a division ends early
// when its quotient overflows. Ten Newton iterations run by default, and the
// next input is taken only after the result of the last has been written.
// One item is in flight at a time; the shared CORDIC unit, divider and root
// set this.
// Reset clears the mean anomaly and all config registers to zero.
// The finished result sits in an output register; the next item is accepted
// while it waits, and the block holds before writing a new result until the
// receiver has taken the old one.
module kepler_anomaly_propagator_top #(
	parameter int ANGLE_BITS        = kap_pkg::ANGLE_BITS_DEF,
	parameter int NEWTON_ITERATIONS = kap_pkg::NEWTON_ITER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [kap_pkg::IDX_W-1:0]   cfg_index,
	input  logic [kap_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // [31:0] mean_anomaly_in
	input  logic                        s_tuser,  // [0] mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [31:0] mean_anomaly_out, [63:32] eccentric_anomaly,
	// [95:64] true anomaly, [121:96] radius, [127:122] zero
	output logic [127:0]                m_tdata
);
	import kap_pkg::*;

	kap_cmd_t    cmd;
	kap_status_t status;

	kap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	kap_datapath #(
		.ANGLE_BITS        (ANGLE_BITS),
		.NEWTON_ITERATIONS (NEWTON_ITERATIONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mode   (s_tuser),
		.in_mean   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== design/kap_cordic.sv =====
// Shared iterative CORDIC: rotation (sine/cosine) and vectoring (atan2).
module kap_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               vec,
	input  logic [31:0]        ang,
	input  logic signed [35:0] xin,
	input  logic signed [35:0] yin,
	output logic signed [35:0] cos_o,
	output logic signed [35:0] sin_o,
	output logic [31:0]        ang_o,
	output logic               done
);
	import kap_pkg::*;

	logic signed [37:0] x_q, y_q, xs, ys, xn, yn;
	logic signed [34:0] z_q, arc;
	logic [4:0]         i_q;
	logic               vec_q, flip_q, base_q, zero_q, busy_q, done_q;
	logic [31:0]        ud, u2;
	logic               fl;
	logic signed [37:0] xa, ya;

	assign ud = ang - 32'h4000_0000;
	assign fl = ~ud[31];
	assign u2 = fl ? (ang ^ 32'h8000_0000) : ang;
	assign xa = 38'(xin);
	assign ya = 38'(yin);

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign arc = 35'(arc_of(i_q));

	always_comb begin
		if (vec_q) begin
			if (!y_q[37]) begin
				xn = x_q + ys;
				yn = y_q - xs;
			end else begin
				xn = x_q - ys;
				yn = y_q + xs;
			end
		end else begin
			if (!z_q[34]) begin
				xn = x_q - ys;
				yn = y_q + xs;
			end else begin
				xn = x_q + ys;
				yn = y_q - xs;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= vec;
			if (vec) begin
				flip_q <= 1'b0;
				base_q <= xin[35];
				zero_q <= (xin == '0) && (yin == '0);
				x_q    <= xin[35] ? -xa : xa;
				y_q    <= xin[35] ? -ya : ya;
				z_q    <= '0;
			end else begin
				flip_q <= fl;
				base_q <= 1'b0;
				zero_q <= 1'b0;
				x_q    <= 38'(CORDIC_GAIN);
				y_q    <= '0;
				z_q    <= 35'($signed(u2));
			end
		end else if (busy_q) begin
			x_q <= xn;
			y_q <= yn;
			if (vec_q ? !y_q[37] : !z_q[34])
				z_q <= vec_q ? z_q + arc : z_q - arc;
			else
				z_q <= vec_q ? z_q - arc : z_q + arc;
		end
	end

	assign cos_o = flip_q ? 36'(-x_q) : 36'(x_q);
	assign sin_o = flip_q ? 36'(-y_q) : 36'(y_q);
	assign ang_o = zero_q ? 32'd0 : ({base_q, 31'd0} + z_q[31:0]);
	assign done  = done_q;

endmodule

// ===== design/kap_divider.sv =====
// Restoring divider, one quotient bit per cycle, with overflow detect.
module kap_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            long_q,
	input  logic [kap_pkg::DIV_NUM_W-1:0]   num,
	input  logic [kap_pkg::DIV_DEN_W-1:0]   den,
	output logic [kap_pkg::DIV_QLONG-1:0]   quot,
	output logic                            sat,
	output logic                            done
);
	import kap_pkg::*;

	localparam int CMP_W = DIV_DEN_W + DIV_QLONG;

	logic [DIV_DEN_W-1:0] rem_q, den_q;
	logic [DIV_NUM_W-1:0] sh_q;
	logic [DIV_QLONG-1:0] quot_q;
	logic [5:0]           cnt_q;
	logic                 busy_q, done_q, sat_q;
	logic [CMP_W-1:0]     den_sh, num_x;
	logic                 ovf;
	logic [DIV_DEN_W:0]   t, td;
	logic                 ge;

	assign den_sh = long_q ? {den, DIV_QLONG'(0)} : CMP_W'({den, DIV_QSHORT'(0)});
	assign num_x  = CMP_W'(num);
	assign ovf    = num_x >= den_sh;
	assign t      = {rem_q, sh_q[DIV_NUM_W-1]};
	assign td     = t - {1'b0, den_q};
	assign ge     = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= long_q ? 6'(DIV_QLONG - 1) : 6'(DIV_QSHORT - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= ovf;
			den_q  <= den;
			quot_q <= '0;
			rem_q  <= long_q ? DIV_DEN_W'(num >> DIV_QLONG) : DIV_DEN_W'(num >> DIV_QSHORT);
			sh_q   <= long_q ? (num << (DIV_NUM_W - DIV_QLONG))
			                 : (num << (DIV_NUM_W - DIV_QSHORT));
		end else if (busy_q) begin
			rem_q  <= ge ? td[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
			sh_q   <= sh_q << 1;
			quot_q <= {quot_q[DIV_QLONG-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign sat  = sat_q;
	assign done = done_q;

endmodule

// ===== design/kap_datapath.sv =====
// Datapath: state, config registers, Newton loop arithmetic, roots, outputs.
module kap_datapath #(
	parameter int ANGLE_BITS        = kap_pkg::ANGLE_BITS_DEF,
	parameter int NEWTON_ITERATIONS = kap_pkg::NEWTON_ITER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kap_pkg::kap_cmd_t           cmd,
	output kap_pkg::kap_status_t        status,
	input  logic                        cfg_we,
	input  logic [kap_pkg::IDX_W-1:0]   cfg_index,
	input  logic [kap_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_mode,
	input  logic [kap_pkg::ANG_W-1:0]   in_mean,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [127:0]                m_tdata
);
	import kap_pkg::*;

	localparam int SD = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
	localparam int SU = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
	localparam int KW = (NEWTON_ITERATIONS > 1) ? $clog2(NEWTON_ITERATIONS) : 1;

	function automatic logic [31:0] to_b32(input logic [ANGLE_BITS-1:0] a);
		logic [63:0] t;
		t = (64'(a) >> SD) << SU;
		return t[31:0];
	endfunction

	function automatic logic [31:0] from_b32(input logic [31:0] b);
		logic [63:0] t;
		t = (64'(b) << SD) >> SU;
		return t[31:0];
	endfunction

	logic [ANGLE_BITS-1:0] cur_m_q, m_next;
	logic [ECC_W-1:0]      ecc_q;
	logic [SMA_W-1:0]      sma_q;
	logic [STP_W-1:0]      stp_q;
	logic signed [35:0]    ea_q, t1_q, ecs_q, sterm_q, xx_q, yy_q;
	logic [31:0]           d_q, ee_q, v32_q;
	logic [58:0]           num_q;
	logic [30:0]           sp_q, sm_q;
	logic                  fneg_q;
	logic [KW-1:0]         k_q;
	logic                  out_valid_q;
	logic [127:0]          out_q;

	logic signed [16:0]    e_s;
	logic signed [36:0]    f, fabs, qs, ean, lo, hi, dn, dr;
	logic [32:0]           qmag;
	logic signed [52:0]    es_p, ec_p;
	logic signed [67:0]    st_p, yy_p, xx_p;

	logic                  cor_start, cor_vec, cor_done;
	logic [31:0]           cor_ang, cor_ang_o;
	logic signed [35:0]    cor_cos, cor_sin;
	logic                  div_start, div_long, div_sat, div_done;
	logic [DIV_NUM_W-1:0]  div_num;
	logic [DIV_DEN_W-1:0]  div_den;
	logic [DIV_QLONG-1:0]  div_quot;

	logic [61:0]           sq_n_q, sq_res_q, sq_bit, sq_try;
	logic [4:0]            sq_j_q;
	logic                  sq_busy_q, sq_done_q, sq_plus_q, sq_start;
	logic [16:0]           sq_arg;

	assign e_s    = $signed({1'b0, ecc_q});
	assign m_next = in_mode ? cur_m_q + ANGLE_BITS'(64'(stp_q))
	                        : ANGLE_BITS'(64'(in_mean));

	assign es_p = e_s * cor_sin;
	assign ec_p = e_s * cor_cos;
	assign st_p = t1_q * RAD_TO_ANGLE + 68'sd536870912;
	assign yy_p = $signed({1'b0, sp_q}) * cor_sin;
	assign xx_p = $signed({1'b0, sm_q}) * cor_cos;

	assign f    = 37'(ea_q) - 37'(sterm_q) - 37'($signed({5'b0, to_b32(cur_m_q)}));
	assign fabs = f[36] ? -f : f;
	assign qmag = (div_sat || div_quot[32] || div_quot[31]) ? 33'h0_8000_0000 : div_quot;
	assign qs   = fneg_q ? -37'($signed({1'b0, qmag})) : 37'($signed({1'b0, qmag}));
	assign ean  = 37'(ea_q) - qs;
	assign hi   = 37'($signed({5'b0, to_b32(cur_m_q)})) + 37'sh0_8000_0000;
	assign lo   = 37'($signed({5'b0, to_b32(cur_m_q)})) - 37'sh0_8000_0000;
	assign dn   = 37'sd1073741824 - 37'(ecs_q);
	assign dr   = 37'sd1073741824 + 37'(ecs_q);

	// shared units
	assign cor_start = cmd.go && ((cmd.op == OP_NT_COR) || (cmd.op == OP_P_COR) ||
	                   (cmd.op == OP_P_ATAN) || (cmd.op == OP_P_COR2));
	assign cor_vec   = (cmd.op == OP_P_ATAN);
	always_comb begin
		case (cmd.op)
			OP_P_COR:  cor_ang = {1'b0, ea_q[31:1]};
			OP_P_COR2: cor_ang = v32_q;
			default:   cor_ang = ea_q[31:0];
		endcase
	end

	assign div_start = cmd.go && ((cmd.op == OP_NT_DIV) || (cmd.op == OP_P_DIV));
	assign div_long  = (cmd.op == OP_NT_DIV);
	assign div_num   = div_long ? {fabs[33:0], 30'd0}
	                            : 64'(num_q) + 64'({d_q, 1'b0});
	assign div_den   = div_long ? DIV_DEN_W'(d_q) : {d_q, 2'b00};

	kap_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.vec    (cor_vec),
		.ang    (cor_ang),
		.xin    (xx_q),
		.yin    (yy_q),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin),
		.ang_o  (cor_ang_o),
		.done   (cor_done)
	);

	kap_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.long_q (div_long),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.sat    (div_sat),
		.done   (div_done)
	);

	// digit-by-digit integer square root
	assign sq_start = cmd.go && ((cmd.op == OP_P_SQP) || (cmd.op == OP_P_SQM));
	assign sq_arg   = (cmd.op == OP_P_SQP) ? 17'd65536 + {1'b0, ecc_q}
	                                       : 17'd65536 - {1'b0, ecc_q};
	assign sq_bit   = 62'd1 << {sq_j_q, 1'b0};
	assign sq_try   = sq_res_q + sq_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_j_q    <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (sq_start) begin
				sq_busy_q <= 1'b1;
				sq_j_q    <= 5'd30;
			end else if (sq_busy_q) begin
				if (sq_j_q == '0) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
				sq_j_q <= sq_j_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			sq_n_q    <= 62'(sq_arg) << 44;
			sq_res_q  <= '0;
			sq_plus_q <= (cmd.op == OP_P_SQP);
		end else if (sq_busy_q) begin
			if (sq_n_q >= sq_try) begin
				sq_n_q   <= sq_n_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
		end
		if (sq_done_q) begin
			if (sq_plus_q)
				sp_q <= sq_res_q[30:0];
			else
				sm_q <= sq_res_q[30:0];
		end
	end

	// control state: mean anomaly, config, loop count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_m_q     <= '0;
			ecc_q       <= '0;
			sma_q       <= '0;
			stp_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ECC: ecc_q <= cfg_data[ECC_W-1:0];
					REG_SMA: sma_q <= cfg_data[SMA_W-1:0];
					REG_STP: stp_q <= cfg_data[STP_W-1:0];
					default: ;
				endcase
			end
			if (m_tready)
				out_valid_q <= 1'b0;
			if (cmd.go) begin
				case (cmd.op)
					OP_LOAD: begin
						cur_m_q <= m_next;
						k_q     <= '0;
					end
					OP_NT_UPD: k_q <= k_q + KW'(1);
					OP_OUT:    out_valid_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// arithmetic payload
	always_ff @(posedge clk) begin
		if (cor_done && (cmd.op == OP_P_ATAN))
			v32_q <= {cor_ang_o[30:0], 1'b0};
		if (cmd.go) begin
			case (cmd.op)
				OP_LOAD:   ea_q <= 36'($signed({1'b0, to_b32(m_next)}));
				OP_NT_M1: begin
					t1_q  <= 36'(es_p >>> 16);
					ecs_q <= 36'(ec_p >>> 16);
				end
				OP_NT_M2: begin
					sterm_q <= 36'(st_p >>> 30);
					d_q     <= (dn < 37'sd1) ? 32'd1 : dn[31:0];
				end
				OP_NT_DIV: fneg_q <= f[36];
				OP_NT_UPD: begin
					if (ean > hi)
						ea_q <= 36'(hi);
					else if (ean < lo)
						ea_q <= 36'(lo);
					else
						ea_q <= 36'(ean);
				end
				OP_P_MUL: begin
					yy_q <= 36'(yy_p >>> 30);
					xx_q <= 36'(xx_p >>> 30);
				end
				OP_P_M1: begin
					ecs_q <= 36'(ec_p >>> 16);
					ee_q  <= ecc_q * ecc_q;
				end
				OP_P_M2: begin
					d_q   <= (dr < 37'sd1) ? 32'd1 : dr[31:0];
					num_q <= sma_q * (33'h1_0000_0000 - {1'b0, ee_q});
				end
				OP_OUT: begin
					out_q[31:0]   <= 32'(64'(cur_m_q));
					out_q[63:32]  <= from_b32(ea_q[31:0]);
					out_q[95:64]  <= from_b32(v32_q);
					out_q[121:96] <= div_sat ? RADIUS_MAX : div_quot[RAD_W-1:0];
					out_q[127:122] <= '0;
				end
				default: ;
			endcase
		end
	end

	assign status.done     = cor_done || div_done || sq_done_q;
	assign status.nt_last  = (k_q == KW'(NEWTON_ITERATIONS - 1));
	assign status.out_busy = out_valid_q && !m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_q;

endmodule

// ===== design/kap_ctrl.sv =====
// Controller: sequences the Newton loop and the post-processing steps.
module kap_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  kap_pkg::kap_status_t status,
	output kap_pkg::kap_cmd_t    cmd
);
	import kap_pkg::*;

	logic [OP_W-1:0] state_q, state_d;
	logic            go_q, unit_op, adv;

	assign unit_op = state_q inside {OP_NT_COR, OP_NT_DIV, OP_P_COR, OP_P_SQP, OP_P_SQM,
	                                 OP_P_ATAN, OP_P_COR2, OP_P_DIV};

	always_comb begin
		case (state_q)
			OP_LOAD: cmd.go = s_tvalid;
			OP_OUT:  cmd.go = !status.out_busy;
			default: cmd.go = go_q;
		endcase
		cmd.op = state_q;
		if (state_q == OP_LOAD || state_q == OP_OUT)
			adv = cmd.go;
		else if (unit_op)
			adv = !go_q && status.done;
		else
			adv = go_q;
	end

	always_comb begin
		case (state_q)
			OP_LOAD:   state_d = OP_NT_COR;
			OP_NT_COR: state_d = OP_NT_M1;
			OP_NT_M1:  state_d = OP_NT_M2;
			OP_NT_M2:  state_d = OP_NT_DIV;
			OP_NT_DIV: state_d = OP_NT_UPD;
			OP_NT_UPD: state_d = status.nt_last ? OP_P_COR : OP_NT_COR;
			OP_P_COR:  state_d = OP_P_SQP;
			OP_P_SQP:  state_d = OP_P_SQM;
			OP_P_SQM:  state_d = OP_P_MUL;
			OP_P_MUL:  state_d = OP_P_ATAN;
			OP_P_ATAN: state_d = OP_P_COR2;
			OP_P_COR2: state_d = OP_P_M1;
			OP_P_M1:   state_d = OP_P_M2;
			OP_P_M2:   state_d = OP_P_DIV;
			OP_P_DIV:  state_d = OP_OUT;
			OP_OUT:    state_d = OP_LOAD;
			default:   state_d = OP_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_LOAD;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (adv) begin
				state_q <= state_d;
				go_q    <= 1'b1;
			end
		end
	end

	assign s_tready = (state_q == OP_LOAD);

	a_go_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> go_q)
		else $error("command strobe missing after a state step");

	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OP_OUT && !status.out_busy) |=> (state_q == OP_LOAD))
		else $error("controller did not return to idle after output");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (unit_op && !go_q))
		else $error("unit finished outside a waiting state");

endmodule

// ===== sim/kepler_anomaly_propagator_top_tb.sv =====
// Testbench of the Kepler anomaly propagator: predicts every result and checks the output stream.
`timescale 1ns / 1ps
module kepler_anomaly_propagator_top_tb;
	import kap_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [31:0] mean_in;
	} orbit_cmd_t;

	typedef struct packed {
		logic [25:0] radius;
		logic [31:0] true_an;
		logic [31:0] ecc_an;
		logic [31:0] mean_an;
	} orbit_state_t;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;
	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam longint HALF = 64'sd2147483648;
	localparam longint ONE30 = 64'sd1073741824;
	localparam int LIMIT = 10000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [127:0] m_tdata;

	kepler_anomaly_propagator_top i_dut (.*);

	initial forever #2 clk = ~clk;

	orbit_cmd_t cmd_q[$];
	orbit_state_t orbit_q[$];
	longint unsigned m_cur, ecc_r, sma_r, stp_r;
	int errors = 0;
	int cycles = 0;
	bit hold = 0;
	int burst = 0, gap = 0;

	function automatic longint fsr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned arc(int i);
		return longint'(arc_of(5'(i)));
	endfunction

	task automatic rotate(input longint unsigned th, output longint c, output longint s);
		longint unsigned u;
		bit flip;
		longint x, y, z, xs, ys;
		u = th & 64'hFFFFFFFF;
		flip = ((u - 64'h40000000) & 64'hFFFFFFFF) < 64'h80000000;
		x = 652032874;
		y = 0;
		if (flip) u ^= 64'h80000000;
		z = longint'(u);
		if (z >= HALF) z -= 2 * HALF;
		for (int i = 0; i < 31; i++) begin
			xs = fsr(x, i);
			ys = fsr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc(i);
			end else begin
				x += ys; y -= xs; z += arc(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned vec_angle(longint x, longint y);
		longint unsigned base;
		longint z, xs, ys;
		base = 0;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; base = 64'h80000000;
		end
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < 31; i++) begin
			xs = fsr(x, i);
			ys = fsr(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += arc(i);
			end else begin
				x -= ys; y += xs; z -= arc(i);
			end
		end
		return (base + longint'(z)) & 64'hFFFFFFFF;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic propagate(input orbit_cmd_t cmd, output orbit_state_t o);
		longint e, m, ea, c, s, d, f, q, xx, yy, st;
		longint unsigned e32, v32, sp, sm, num, den, r;
		e = longint'(ecc_r);
		if (cmd.mode == MODE_LOAD) m_cur = 64'(cmd.mean_in);
		else m_cur = (m_cur + stp_r) & 64'hFFFFFFFF;
		m = longint'(m_cur);
		ea = m;
		for (int k = 0; k < NEWTON_ITER_DEF; k++) begin
			rotate(ea, c, s);
			st = fsr(fsr(e * s, 16) * 683565276 + (ONE30 >> 1), 30);
			f = ea - st - m;
			d = ONE30 - fsr(e * c, 16);
			if (d < 1) d = 1;
			q = (f * ONE30) / d;
			if (q > HALF) q = HALF;
			if (q < -HALF) q = -HALF;
			ea -= q;
			if (ea > m + HALF) ea = m + HALF;
			if (ea < m - HALF) ea = m - HALF;
		end
		e32 = ea & 64'hFFFFFFFF;
		rotate(e32 >> 1, c, s);
		sp = int_root(longint'(65536 + e) << 44);
		sm = int_root(longint'(65536 - e) << 44);
		yy = fsr(longint'(sp) * s, 30);
		xx = fsr(longint'(sm) * c, 30);
		v32 = (vec_angle(xx, yy) << 1) & 64'hFFFFFFFF;
		rotate(v32, c, s);
		d = ONE30 + fsr(e * c, 16);
		if (d < 1) d = 1;
		den = d;
		num = sma_r * ((64'd1 << 32) - ecc_r * ecc_r);
		r = (num + 2 * den) / (4 * den);
		if (r > 64'd67108863) r = 64'd67108863;
		o.mean_an = m_cur[31:0];
		o.ecc_an = e32[31:0];
		o.true_an = v32[31:0];
		o.radius = r[25:0];
	endtask

	// driver
	always @(posedge clk) begin
		orbit_state_t o;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				propagate(cmd_q.pop_front(), o);
				orbit_q.insert(orbit_q.size(), o);
			end
			if (!s_tvalid || s_tready) begin
				if (burst > 0 && !hold && cmd_q.size() > 0) begin
					s_tvalid <= 1;
					{s_tuser, s_tdata} <= cmd_q[0];
					burst <= burst - 1;
				end else begin
					s_tvalid <= 0;
					if (gap > 0) gap <= gap - 1;
					else begin
						burst <= $urandom_range(1, 8);
						gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1500);
					end
				end
			end
			m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 3000 < 1000);
		end
	end

	// monitor
	always @(posedge clk) begin
		orbit_state_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = orbit_state_t'(m_tdata[121:0]);
			if (orbit_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transaction %h", m_tdata);
			end else begin
				want = orbit_q.pop_front();
				if (got !== want || m_tdata[127:122] !== '0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h actual %h", want, m_tdata[121:0]);
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (cmd_q.size() > 0 || s_tvalid || orbit_q.size() > 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input longint unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ECC: ecc_r = val & 64'hFFFF;
			REG_SMA: sma_r = val & 64'h3FFFFFF;
			REG_STP: stp_r = val & 64'hFFFFFFFF;
			default: ;
		endcase
	endtask

	task automatic add_cmd(input logic mode, input logic [31:0] ma);
		orbit_cmd_t c;
		c.mode = mode;
		c.mean_in = ma;
		cmd_q.insert(cmd_q.size(), c);
	endtask

	initial begin
		logic [15:0] ecc_set[4] = '{16'd0, 16'd65535, 16'd32768, 16'd1000};
		m_cur = 0; ecc_r = 0; sma_r = 0; stp_r = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// directed: defaults, then extremes
		add_cmd(MODE_ADVANCE, 32'hFFFFFFFF);
		add_cmd(MODE_LOAD, 32'h0);
		add_cmd(MODE_LOAD, 32'hFFFFFFFF);
		wait_idle();
		write_reg(REG_ECC, 16'hFFFF);
		write_reg(REG_SMA, 26'h3FFFFFF);
		write_reg(REG_STP, 32'hFFFFFFFF);
		foreach (ecc_set[i]) begin
			add_cmd(MODE_LOAD, 32'h0);
			add_cmd(MODE_LOAD, 32'h80000000);
			add_cmd(MODE_LOAD, 32'h7FFFFFFF);
			add_cmd(MODE_ADVANCE, 32'h0);
			add_cmd(MODE_ADVANCE, 32'h12345678);
			wait_idle();
			write_reg(REG_ECC, ecc_set[i]);
		end
		write_reg(REG_NONE, 32'hFFFFFFFF);
		// random phases, each drained at its end; in phase 5 the sender is also held until drained
		for (int p = 0; p < 10; p++) begin
			write_reg(REG_ECC, $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom);
			write_reg(REG_SMA, $urandom_range(0, 3) == 0 ? 26'h3FFFFFF : $urandom);
			write_reg(REG_STP, $urandom);
			for (int n = 0; n < 100; n++)
				add_cmd($urandom_range(0, 2) != 0, $urandom);
			if (p == 5) begin
				while (cmd_q.size() > 50) @(posedge clk);
				hold <= 1'b1;
				@(posedge clk);
				while (s_tvalid || orbit_q.size() > 0) @(posedge clk);
				repeat (200) @(posedge clk);
				hold <= 1'b0;
			end
			wait_idle();
		end
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

// ===== kepler_anomaly_propagator_top.f =====
design/kap_pkg.sv
design/kap_cordic.sv
design/kap_divider.sv
design/kap_datapath.sv
design/kap_ctrl.sv
design/kepler_anomaly_propagator_top.sv
sim/kepler_anomaly_propagator_top_tb.sv
